// ----- hdl/ssc_pkg.sv -----
// ssc_pkg: shared constants, types and helpers of the span coverage row block
`default_nettype none

package ssc_pkg;

  // grid and window sizes (subsample count is a power of two)
  localparam int SUBSAMPLE  = 8;
  localparam int MAX_WIDTH  = 64;
  localparam int SUB_BITS   = $clog2(SUBSAMPLE);
  localparam int PIX_W      = $clog2(MAX_WIDTH);
  localparam int CNT_W      = $clog2(MAX_WIDTH + 1);
  localparam int POS_W      = $clog2(MAX_WIDTH * SUBSAMPLE + 1);
  localparam int OV_W       = $clog2(SUBSAMPLE + 1);
  localparam int FULL_AREA  = SUBSAMPLE * SUBSAMPLE;
  localparam int ACC_W      = $clog2(FULL_AREA + 1);

  // field widths
  localparam int VAL_W      = 7;
  localparam int ONE_VALUE  = 64;
  localparam int TILE_W     = 16;
  localparam int WIDTH_W    = 7;
  localparam int EDGE_W     = 20;
  localparam int BASE_W     = TILE_W + SUB_BITS;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TILE_X    = 1'b0,
    REG_ROW_WIDTH = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_SPAN = 1'b1
  } item_kind_e;

  // span clipped to the window, in window-relative subsample units
  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] left;
    logic [POS_W-1:0] right;
    logic [PIX_W-1:0] first;
    logic [PIX_W-1:0] last;
  } clip_t;

  // covered cells to 1/64 units, rounded
  function automatic logic [VAL_W-1:0] scale_cov(input logic [ACC_W-1:0] acc);
    logic [ACC_W+VAL_W:0] num;
    num = (ACC_W+VAL_W+1)'(acc) * (ACC_W+VAL_W+1)'(ONE_VALUE)
        + (ACC_W+VAL_W+1)'(FULL_AREA / 2);
    return VAL_W'(num / FULL_AREA);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/ssc_ram.sv -----
// ssc_ram: single write port, single registered read port memory
`default_nettype none

module ssc_ram #(
  parameter int DATA_W = 7,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ssc_span_clip.sv -----
// ssc_span_clip: clips a span to the row window and finds its pixel range
`default_nettype none

module ssc_span_clip import ssc_pkg::*; (
  input  logic [TILE_W-1:0] tile_x_i,
  input  logic [CNT_W-1:0]  eff_width_i,
  input  logic [EDGE_W-1:0] left_i,
  input  logic [EDGE_W-1:0] right_i,
  input  logic              in_shape_i,
  output clip_t             clip_o
);

  logic [BASE_W-1:0]  base;
  logic [POS_W-1:0]   lim;
  logic [EDGE_W:0]    diff_l;
  logic [EDGE_W:0]    diff_r;
  logic [POS_W-1:0]   rel_l;
  logic [POS_W-1:0]   rel_r;
  logic [POS_W-1:0]   rel_r_m1;

  function automatic logic [POS_W-1:0] clamp(input logic [EDGE_W:0] d,
                                             input logic [POS_W-1:0] top);
    logic [POS_W-1:0] r;
    if (d[EDGE_W]) begin
      r = '0;
    end else if (d[EDGE_W-1:0] > EDGE_W'(top)) begin
      r = top;
    end else begin
      r = POS_W'(d[EDGE_W-1:0]);
    end
    return r;
  endfunction

  assign base   = {tile_x_i, SUB_BITS'(0)};
  assign lim    = POS_W'({eff_width_i, SUB_BITS'(0)});
  assign diff_l = (EDGE_W+1)'(left_i) - (EDGE_W+1)'(base);
  assign diff_r = (EDGE_W+1)'(right_i) - (EDGE_W+1)'(base);
  assign rel_l  = clamp(diff_l, lim);
  assign rel_r  = clamp(diff_r, lim);
  assign rel_r_m1 = rel_r - POS_W'(1);

  always_comb begin
    clip_o.hit   = in_shape_i && (left_i <= right_i) && (rel_l < rel_r);
    clip_o.left  = rel_l;
    clip_o.right = rel_r;
    clip_o.first = PIX_W'(rel_l >> SUB_BITS);
    clip_o.last  = PIX_W'(rel_r_m1 >> SUB_BITS);
  end

endmodule

`default_nettype wire

// ----- hdl/subsampled_span_coverage_row.sv -----
// subsampled_span_coverage_row: anti-aliased coverage of one mask row from sub-row spans
// load item: written in the cycle it is taken, busy stays low, back to back
// span item: a clip step (PREP), a RUN step for each pixel it touches, then a write-back step (DRAIN)
//   (a span that misses the window skips RUN and DRAIN); the accumulator memory port sets this
// last span: then the emit pass walks every window pixel, results one per cycle, each
//   through emit stage 1 and the output registers; the receiver cannot stall
// reset: registers to tile_x 0, row_width 64, accumulators read as zero
`default_nettype none

module subsampled_span_coverage_row import ssc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // item channel
  input  logic                  start,
  output logic                  busy,
  input  logic                  kind_i,
  input  logic [5:0]            load_index_i,
  input  logic [VAL_W-1:0]      old_value_i,
  input  logic [EDGE_W-1:0]     span_left_i,
  input  logic [EDGE_W-1:0]     span_right_i,
  input  logic                  span_in_shape_i,
  input  logic                  last_span_i,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // results
  output logic                  result_valid_o,
  output logic [5:0]            pixel_index_o,
  output logic [VAL_W-1:0]      coverage_o,
  output logic                  last_pixel_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [TILE_W-1:0]  tile_x_q;
  logic [WIDTH_W-1:0] row_width_q;
  logic [CNT_W-1:0]   eff_width;
  logic [PIX_W-1:0]   last_col;

  // captured span item
  logic [EDGE_W-1:0]  left_q;
  logic [EDGE_W-1:0]  right_q;
  logic               in_shape_q;
  logic               last_span_q;

  // clipped span and pixel walk
  clip_t              clip;
  logic [POS_W-1:0]   rel_l_q;
  logic [POS_W-1:0]   rel_r_q;
  logic [PIX_W-1:0]   ptr_q;
  logic [PIX_W-1:0]   end_q;

  // accumulator valid bits: an entry not valid reads as zero
  logic [MAX_WIDTH-1:0] acc_vld_q;

  // read-modify-write stage
  logic               wr_pend_q;
  logic [PIX_W-1:0]   wr_addr_q;
  logic [OV_W-1:0]    ov_q;
  logic               wr_vld_q;

  // emit stage 1 (memory read data arrives here)
  logic               em_pend_q;
  logic [PIX_W-1:0]   em_idx_q;
  logic               em_last_q;
  logic               em_accv_q;

  // output registers
  logic               result_valid_q;
  logic [5:0]         pix_q;
  logic [VAL_W-1:0]   cov_q;
  logic               last_pix_q;

  logic               accept;
  logic               accept_load;
  logic               accept_span;

  // overlap of current pixel with the clipped span
  logic [POS_W-1:0]   cell_lo;
  logic [POS_W-1:0]   cell_hi;
  logic [POS_W-1:0]   ov_a;
  logic [POS_W-1:0]   ov_b;
  logic [OV_W-1:0]    ov;

  // memory ports
  logic               acc_re;
  logic [ACC_W-1:0]   acc_rdata;
  logic [ACC_W:0]     acc_sum;
  logic [ACC_W-1:0]   acc_wdata;
  logic               old_we;
  logic [VAL_W-1:0]   old_wdata;
  logic               old_re;
  logic [VAL_W-1:0]   old_rdata;

  logic [ACC_W-1:0]   em_acc;
  logic [VAL_W-1:0]   em_cov;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign accept_load = accept && (item_kind_e'(kind_i) == KIND_LOAD);
  assign accept_span = accept && (item_kind_e'(kind_i) == KIND_SPAN);

  // widths past the storage are cut to it
  assign eff_width = (int'(row_width_q) > MAX_WIDTH) ? CNT_W'(MAX_WIDTH)
                                                      : CNT_W'(row_width_q);
  assign last_col  = PIX_W'(eff_width - CNT_W'(1));

  ssc_span_clip u_clip (
    .tile_x_i    (tile_x_q),
    .eff_width_i (eff_width),
    .left_i      (left_q),
    .right_i     (right_q),
    .in_shape_i  (in_shape_q),
    .clip_o      (clip)
  );

  // pixel ptr_q spans subsamples [ptr*S, ptr*S+S)
  assign cell_lo = POS_W'({ptr_q, SUB_BITS'(0)});
  assign cell_hi = cell_lo + POS_W'(SUBSAMPLE);
  assign ov_a    = (rel_l_q > cell_lo) ? rel_l_q : cell_lo;
  assign ov_b    = (rel_r_q < cell_hi) ? rel_r_q : cell_hi;
  assign ov      = OV_W'(ov_b - ov_a);

  // accumulate with saturation at a fully covered pixel
  assign acc_sum   = (ACC_W+1)'(wr_vld_q ? acc_rdata : '0) + (ACC_W+1)'(ov_q);
  assign acc_wdata = (acc_sum > (ACC_W+1)'(FULL_AREA)) ? ACC_W'(FULL_AREA)
                                                       : ACC_W'(acc_sum);

  assign acc_re = (state_q == ST_RUN) || (state_q == ST_EMIT);
  assign old_re = (state_q == ST_EMIT);

  // old values above full coverage saturate when loaded
  assign old_we    = accept_load;
  assign old_wdata = (old_value_i > VAL_W'(ONE_VALUE)) ? VAL_W'(ONE_VALUE) : old_value_i;

  ssc_ram #(
    .DATA_W (ACC_W),
    .DEPTH  (MAX_WIDTH)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (wr_pend_q),
    .waddr_i (wr_addr_q),
    .wdata_i (acc_wdata),
    .re_i    (acc_re),
    .raddr_i (ptr_q),
    .rdata_o (acc_rdata)
  );

  ssc_ram #(
    .DATA_W (VAL_W),
    .DEPTH  (MAX_WIDTH)
  ) u_old_ram (
    .clk_i   (clk_i),
    .we_i    (old_we),
    .waddr_i (load_index_i[PIX_W-1:0]),
    .wdata_i (old_wdata),
    .re_i    (old_re),
    .raddr_i (ptr_q),
    .rdata_o (old_rdata)
  );

  // result value: max of old mask value and scaled coverage
  assign em_acc = em_accv_q ? acc_rdata : '0;
  assign em_cov = scale_cov(em_acc);

  // control: state, walk counter, valid bits, configuration, strobes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      tile_x_q       <= '0;
      row_width_q    <= WIDTH_W'(64);
      ptr_q          <= '0;
      end_q          <= '0;
      last_span_q    <= 1'b0;
      acc_vld_q      <= '0;
      wr_pend_q      <= 1'b0;
      em_pend_q      <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_TILE_X:    tile_x_q    <= cfg_wdata_i[TILE_W-1:0];
          REG_ROW_WIDTH: row_width_q <= cfg_wdata_i[WIDTH_W-1:0];
        endcase
      end

      wr_pend_q      <= (state_q == ST_RUN);
      em_pend_q      <= (state_q == ST_EMIT);
      result_valid_q <= em_pend_q;

      if (wr_pend_q) begin
        acc_vld_q[wr_addr_q] <= 1'b1;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept_span) begin
            last_span_q <= last_span_i;
            state_q     <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (clip.hit) begin
            ptr_q   <= clip.first;
            end_q   <= clip.last;
            state_q <= ST_RUN;
          end else if (last_span_q && (eff_width != '0)) begin
            ptr_q   <= '0;
            state_q <= ST_EMIT;
          end else begin
            // rejected span; a zero-wide row still clears on its last span
            if (last_span_q) begin
              acc_vld_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        ST_RUN: begin
          if (ptr_q == end_q) begin
            state_q <= ST_DRAIN;
          end else begin
            ptr_q <= ptr_q + PIX_W'(1);
          end
        end
        ST_DRAIN: begin
          // last write-back lands here, so the emit pass reads fresh data
          if (last_span_q && (eff_width != '0)) begin
            ptr_q   <= '0;
            state_q <= ST_EMIT;
          end else begin
            if (last_span_q) begin
              acc_vld_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (ptr_q == last_col) begin
            acc_vld_q <= '0;
            state_q   <= ST_IDLE;
          end else begin
            ptr_q <= ptr_q + PIX_W'(1);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept_span) begin
      left_q     <= span_left_i;
      right_q    <= span_right_i;
      in_shape_q <= span_in_shape_i;
    end
    if (state_q == ST_PREP) begin
      rel_l_q <= clip.left;
      rel_r_q <= clip.right;
    end
    wr_addr_q <= ptr_q;
    ov_q      <= ov;
    wr_vld_q  <= acc_vld_q[ptr_q];
    em_idx_q  <= ptr_q;
    em_last_q <= (ptr_q == last_col);
    em_accv_q <= acc_vld_q[ptr_q];
    pix_q      <= 6'(em_idx_q);
    cov_q      <= (old_rdata > em_cov) ? old_rdata : em_cov;
    last_pix_q <= em_last_q;
  end

  assign result_valid_o = result_valid_q;
  assign pixel_index_o  = pix_q;
  assign coverage_o     = cov_q;
  assign last_pixel_o   = last_pix_q;

endmodule

`default_nettype wire

// ----- hdl/ssc_checker.sv -----
// ssc_checker: port-level checks of the span coverage row block, bound to the top
`default_nettype none

module ssc_checker import ssc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             kind_i,
  input logic             result_valid_o,
  input logic [5:0]       pixel_index_o,
  input logic             last_pixel_o
);

  // a span item always raises busy in the cycle after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (item_kind_e'(kind_i) == KIND_SPAN) |=> busy)
    else $error("span item did not raise busy");

  // pixels of a row come out in consecutive positions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_pixel_o |=>
      result_valid_o && (pixel_index_o == $past(pixel_index_o) + 6'd1))
    else $error("row results not consecutive");

  // a row that is not at its first pixel continues a running burst
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (pixel_index_o != 6'd0) |-> $past(result_valid_o))
    else $error("row result out of a burst");

  // the final pixel closes the burst
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_pixel_o |=> !result_valid_o)
    else $error("result after the final pixel");

endmodule

bind subsampled_span_coverage_row ssc_checker u_ssc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .kind_i         (kind_i),
  .result_valid_o (result_valid_o),
  .pixel_index_o  (pixel_index_o),
  .last_pixel_o   (last_pixel_o)
);

`default_nettype wire
